### hdl/hsl_to_rgb_converter_defines.svh
// ----------------------------------------------------------------------------
// HSL to RGB converter assertion macros
// Shared property wrappers, clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication.
`define HSL_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("hsl_to_rgb_converter: same-cycle check failed");

// Next-cycle implication.
`define HSL_ASSERT_NXT(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("hsl_to_rgb_converter: next-cycle check failed");

`endif

### hdl/hsl2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Shared widths and the hue region codes used by the channel pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hsl2rgb_pkg;

    localparam int DATA_W = 16;

    // Piece of the hue-to-channel curve that a channel falls in.
    typedef enum logic [1:0] {
        REGION_RISE,
        REGION_TOP,
        REGION_FALL,
        REGION_LOW
    } region_t;

endpackage

`default_nettype wire

### hdl/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Streaming per-pixel conversion of HSL plus alpha to RGB plus alpha.
// ----------------------------------------------------------------------------
// Converts one pixel per clock. The datapath is five register stages: input
// clamp, lightness times saturation together with the hue offsets, q/p and the
// ramp slope, one multiplier per channel, and the final rounding, select and
// clamp in the output register. m_valid is driven by the valid flag of that
// register; with m_ready held high a new pixel is taken every cycle.
// Backpressure only stalls the stages that are full, so empty slots are
// squeezed out before s_ready drops. Alpha travels alongside and comes out
// unchanged.
`default_nettype none

module hsl_to_rgb_converter #(
    parameter int FRAC_BITS = 15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_hue,
    input  wire logic [15:0] s_saturation,
    input  wire logic [15:0] s_lightness,
    input  wire logic [15:0] s_alpha_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_red,
    output logic [15:0]      m_green,
    output logic [15:0]      m_blue,
    output logic [15:0]      m_alpha_out
);

    import hsl2rgb_pkg::*;

    `include "hsl_to_rgb_converter_defines.svh"

    localparam int F   = FRAC_BITS;
    localparam int UW  = F + 1;                       // clamped input, 0..ONE
    localparam int SW  = F + 3;                       // signed hue/q/p width
    localparam int DW  = F + 2;                       // q - p
    localparam int MW  = F + 3;                       // 6 * ramp position
    localparam int LPW = 2 * F + 2;                   // l * s
    localparam int CPW = DW + MW;                     // d * 6k
    localparam int VW  = F + 6;                       // final signed sum
    localparam int CW  = (F + 1 > DATA_W) ? F + 1 : DATA_W;

    localparam longint ONE_I   = longint'(1) << F;
    localparam longint OUT_I   = (ONE_I < 65535) ? ONE_I : 65535;

    localparam logic [CW-1:0]        ONE_C   = CW'(ONE_I);
    localparam logic signed [SW-1:0] ONE_S   = SW'(ONE_I);
    localparam logic signed [SW-1:0] HALF_S  = SW'(ONE_I >> 1);
    localparam logic signed [SW-1:0] THIRD_S = SW'((ONE_I + 1) / 3);
    localparam logic signed [SW-1:0] SIXTH_S = SW'((ONE_I + 3) / 6);
    localparam logic signed [SW-1:0] TWO3_S  = SW'((2 * ONE_I + 1) / 3);
    localparam logic [LPW-1:0]       HALF_LP = LPW'(ONE_I >> 1);
    localparam logic [CPW-1:0]       HALF_CP = CPW'(ONE_I >> 1);
    localparam logic signed [VW-1:0] OUT_MAX = VW'(OUT_I);
    localparam logic [15:0]          OUT_MAX16 = 16'(OUT_I);

    function automatic logic [UW-1:0] clamp_in(input logic [15:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        if (w > ONE_C) begin
            w = ONE_C;
        end
        return w[UW-1:0];
    endfunction

    // ---------------- stage enables ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5     = !v5_reg || m_ready;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // ---------------- stage 1: clamp inputs ----------------
    logic [UW-1:0] h1_reg, s1_reg, l1_reg;
    logic [15:0]   a1_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            h1_reg <= clamp_in(s_hue);
            s1_reg <= clamp_in(s_saturation);
            l1_reg <= clamp_in(s_lightness);
            a1_reg <= s_alpha_in;
        end
    end

    // ---------------- stage 2: l * s, hue offsets ----------------
    logic [LPW-1:0]        ls_prod_next, ls_prod2_reg;
    logic signed [SW-1:0]  t_next [3];
    logic signed [SW-1:0]  t2_reg [3];
    logic [UW-1:0]         s2_reg, l2_reg;
    logic [15:0]           a2_reg;

    always_comb begin
        logic signed [SW-1:0] h;
        logic signed [SW-1:0] t;
        h = $signed({2'b00, h1_reg});
        ls_prod_next = LPW'(l1_reg) * LPW'(s1_reg);
        for (int c = 0; c < 3; c++) begin
            // red leads by a third, blue trails by a third
            if (c == 0) begin
                t = h + THIRD_S;
            end else if (c == 1) begin
                t = h;
            end else begin
                t = h - THIRD_S;
            end
            if (t < 0) begin
                t = t + ONE_S;
            end
            if (t > ONE_S) begin
                t = t - ONE_S;
            end
            t_next[c] = t;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            ls_prod2_reg <= ls_prod_next;
            t2_reg       <= t_next;
            s2_reg       <= s1_reg;
            l2_reg       <= l1_reg;
            a2_reg       <= a1_reg;
        end
    end

    // ---------------- stage 3: q, p, slope, region ----------------
    logic signed [SW-1:0] q_next, p_next, q3_reg, p3_reg;
    logic [DW-1:0]        d_next, d3_reg;
    logic [MW-1:0]        m_next [3];
    logic [MW-1:0]        m3_reg [3];
    region_t              rg_next [3];
    region_t              rg3_reg [3];
    logic [15:0]          a3_reg;

    always_comb begin
        logic [LPW-1:0]       ls_sum;
        logic signed [SW-1:0] ls, l, s, diff, k;
        logic [MW-1:0]        ku;
        ls_sum = ls_prod2_reg + HALF_LP;
        ls     = $signed({1'b0, ls_sum[LPW-1 -: F + 2]});
        l      = $signed({2'b00, l2_reg});
        s      = $signed({2'b00, s2_reg});
        q_next = (l < HALF_S) ? l + ls : l + s - ls;
        p_next = (l <<< 1) - q_next;
        diff   = q_next - p_next;
        d_next = (diff < 0) ? '0 : diff[DW-1:0];
        for (int c = 0; c < 3; c++) begin
            if (t2_reg[c] < SIXTH_S) begin
                rg_next[c] = REGION_RISE;
                k          = t2_reg[c];
            end else if (t2_reg[c] < HALF_S) begin
                rg_next[c] = REGION_TOP;
                k          = '0;
            end else if (t2_reg[c] < TWO3_S) begin
                rg_next[c] = REGION_FALL;
                k          = TWO3_S - t2_reg[c];
            end else begin
                rg_next[c] = REGION_LOW;
                k          = '0;
            end
            ku        = MW'(k[SW-2:0]);
            m_next[c] = (ku << 2) + (ku << 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            q3_reg  <= q_next;
            p3_reg  <= p_next;
            d3_reg  <= d_next;
            m3_reg  <= m_next;
            rg3_reg <= rg_next;
            a3_reg  <= a2_reg;
        end
    end

    // ---------------- stage 4: ramp multiply ----------------
    logic [CPW-1:0]       prod_next [3];
    logic [CPW-1:0]       prod4_reg [3];
    logic signed [SW-1:0] q4_reg, p4_reg;
    region_t              rg4_reg [3];
    logic [15:0]          a4_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod_next[c] = CPW'(d3_reg) * CPW'(m3_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            prod4_reg <= prod_next;
            q4_reg    <= q3_reg;
            p4_reg    <= p3_reg;
            rg4_reg   <= rg3_reg;
            a4_reg    <= a3_reg;
        end
    end

    // ---------------- stage 5: round, select, clamp ----------------
    logic [15:0] ch_next [3];
    logic [15:0] ch5_reg [3];
    logic [15:0] a5_reg;

    always_comb begin
        logic [CPW-1:0]       rsum;
        logic signed [VW-1:0] p, q, v;
        p = $signed({{(VW - SW){p4_reg[SW-1]}}, p4_reg});
        q = $signed({{(VW - SW){q4_reg[SW-1]}}, q4_reg});
        for (int c = 0; c < 3; c++) begin
            rsum = prod4_reg[c] + HALF_CP;
            case (rg4_reg[c])
                REGION_RISE,
                REGION_FALL: v = p + $signed({1'b0, rsum[CPW-1 -: VW - 1]});
                REGION_TOP:  v = q;
                default:     v = p;
            endcase
            if (v < 0) begin
                v = '0;
            end else if (v > OUT_MAX) begin
                v = OUT_MAX;
            end
            ch_next[c] = v[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            ch5_reg <= ch_next;
            a5_reg  <= a4_reg;
        end
    end

    assign m_valid     = v5_reg;
    assign m_red       = ch5_reg[0];
    assign m_green     = ch5_reg[1];
    assign m_blue      = ch5_reg[2];
    assign m_alpha_out = a5_reg;

    // ---------------- checks ----------------
    `HSL_ASSERT_IMP(a_out_range, m_valid,
        m_red <= OUT_MAX16 && m_green <= OUT_MAX16 && m_blue <= OUT_MAX16)
    `HSL_ASSERT_IMP(a_full_stall, v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && !m_ready,
        !s_ready)
    `HSL_ASSERT_NXT(a_accept_fills, s_valid && s_ready, v1_reg)

endmodule

`default_nettype wire
